### rtl/grid_value_interpolator_macros.svh
// Assertion helpers shared by the RTL of the interpolator.
`ifndef GRID_VALUE_INTERPOLATOR_MACROS_SVH
`define GRID_VALUE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define GVI_ASSERT_IMPLIES(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("grid_value_interpolator: check failed");

// Next-cycle implication, quiet while reset is asserted.
`define GVI_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("grid_value_interpolator: check failed");

`endif

### rtl/gvi_pkg.sv
package gvi_pkg;

    localparam int POINTS_MAX_DEF = 16;
    localparam int LAYERS_DEF     = 16;

    localparam int VAL_W      = 32;
    localparam int ADDR_IN_W  = 12;
    localparam int LAYER_W    = 4;
    localparam int CNT_W      = 5;
    localparam int SP_W       = 31;
    localparam int FRAC_W     = 16;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_ONE  = 65536;
    localparam int XW         = 48;
    localparam int DIV_W      = 48;
    localparam int DIV_TOP_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PTS_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PTS_SEC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SP_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_SEC   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SP_SEC    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAST      = 3'd7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                        command;
        logic [ADDR_IN_W-1:0]        entry_address;
        logic signed [VAL_W-1:0]     entry_value;
        logic signed [VAL_W-1:0]     coord_first;
        logic signed [VAL_W-1:0]     coord_second;
        logic [LAYER_W-1:0]          layer;
    } gvi_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]     value;
        logic                        status;
    } gvi_rsp_t;

    typedef struct packed {
        logic                        start;
        logic [DIV_TOP_W-1:0]        top;
    } gvi_div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
    } gvi_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_WRITE,
        ST_SPAN,
        ST_CLAMP,
        ST_IDIV,
        ST_ADIV,
        ST_FETCH,
        ST_BLEND,
        ST_DONE
    } gvi_state_t;

endpackage

### rtl/gvi_ram.sv
module gvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gvi_div.sv
// Restoring divider, one quotient bit per cycle from bit 'top' down to 0.
// The caller guarantees the quotient fits below 2**(top+1).
module gvi_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gvi_pkg::gvi_div_req_t           ctl,
    input  logic [gvi_pkg::DIV_W-1:0]       dividend,
    input  logic [gvi_pkg::SP_W-1:0]        divisor,
    output gvi_pkg::gvi_div_stat_t          stat,
    output logic [gvi_pkg::ALPHA_W-1:0]     quotient,
    output logic [gvi_pkg::DIV_W-1:0]       remainder
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [gvi_pkg::DIV_TOP_W-1:0]    k_reg;
    logic [gvi_pkg::DIV_W-1:0]        rem_reg;
    logic [gvi_pkg::ALPHA_W-1:0]      q_reg;
    logic [gvi_pkg::SP_W-1:0]         dvs_reg;
    logic [gvi_pkg::DIV_W-1:0]        shifted;
    logic                             fits;

    assign shifted = gvi_pkg::DIV_W'(dvs_reg) << k_reg;
    assign fits    = (rem_reg >= shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= ctl.top;
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= dividend;
            q_reg   <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg && fits)
        begin
            rem_reg <= rem_reg - shifted;
            q_reg   <= q_reg | (gvi_pkg::ALPHA_W'(1) << k_reg);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

### rtl/grid_value_interpolator.sv
// Layered Q16.16 lookup table on a uniform 1-D or 2-D grid, read back by
// linear or bilinear interpolation.
// Channels: req (req_valid/req_stall) carries write and query beats; rsp
// (rsp_valid/rsp_stall) carries one beat per query, none per write. A beat
// moves on a clock edge with valid high and stall low. cfg_write/cfg_index/
// cfg_data set the grid registers; write them only while the block is idle.
// One item at a time: req_stall is high from acceptance until the sequencer
// is back in idle. A write passes the wrap state, one step per subtraction
// of the store depth from an address beyond it (none at the default size),
// then the write state. A query runs per dimension: span, clamp, a cell-index
// division of log2(POINTS_MAX) steps and a 17-step alpha division on the
// shared divider; then four store reads and three blends on one multiplier.
// The result beat is loaded from the done state, and the next request beat
// is taken once the sequencer is back in idle; clamped and on-point
// coordinates skip divisions and finish sooner. A layer above last_layer
// goes straight to the done state and answers with zero and range status.
// The result sits in an output register; while rsp is stalled and that
// register is full the finished query holds in its last state.
// Reset clears the sequencer and loads the register defaults; the table
// itself is not cleared and must be written before it is read.
module grid_value_interpolator #(
    parameter int POINTS_MAX = gvi_pkg::POINTS_MAX_DEF,
    parameter int LAYERS     = gvi_pkg::LAYERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  gvi_pkg::gvi_req_t                  req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output gvi_pkg::gvi_rsp_t                  rsp,
    input  logic                               cfg_write,
    input  logic [gvi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gvi_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "grid_value_interpolator_macros.svh"

    localparam int STRIDE  = POINTS_MAX * POINTS_MAX;
    localparam int DEPTH   = LAYERS * STRIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = $clog2(POINTS_MAX);
    localparam int NW      = $clog2(POINTS_MAX + 1);
    localparam int ACC_RAW = $clog2(16 * STRIDE + 4096);
    localparam int ACC_W   = (ACC_RAW > AW + 1) ? ACC_RAW : AW + 1;

    // grid registers
    logic [1:0]                       dims_reg;
    logic [gvi_pkg::CNT_W-1:0]        pf_reg;
    logic [gvi_pkg::CNT_W-1:0]        ps_reg;
    logic signed [gvi_pkg::VAL_W-1:0] of_reg;
    logic [gvi_pkg::SP_W-1:0]         sf_reg;
    logic signed [gvi_pkg::VAL_W-1:0] os_reg;
    logic [gvi_pkg::SP_W-1:0]         ss_reg;
    logic [gvi_pkg::LAYER_W-1:0]      ll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= 2'd1;
            pf_reg   <= 5'd16;
            ps_reg   <= 5'd16;
            of_reg   <= '0;
            sf_reg   <= 31'd65536;
            os_reg   <= '0;
            ss_reg   <= 31'd65536;
            ll_reg   <= 4'd15;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gvi_pkg::REG_DIMS:      dims_reg <= cfg_data[1:0];
                gvi_pkg::REG_PTS_FIRST: pf_reg   <= cfg_data[gvi_pkg::CNT_W-1:0];
                gvi_pkg::REG_PTS_SEC:   ps_reg   <= cfg_data[gvi_pkg::CNT_W-1:0];
                gvi_pkg::REG_ORG_FIRST: of_reg   <= cfg_data;
                gvi_pkg::REG_SP_FIRST:  sf_reg   <= cfg_data[gvi_pkg::SP_W-1:0];
                gvi_pkg::REG_ORG_SEC:   os_reg   <= cfg_data;
                gvi_pkg::REG_SP_SEC:    ss_reg   <= cfg_data[gvi_pkg::SP_W-1:0];
                gvi_pkg::REG_LAST:      ll_reg   <= cfg_data[gvi_pkg::LAYER_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [NW-1:0] clamp_pts(input logic [gvi_pkg::CNT_W-1:0] n);
        logic [NW-1:0] c;
        if (n < 5'd2)
            c = NW'(2);
        else if (int'(n) > POINTS_MAX)
            c = NW'(POINTS_MAX);
        else
            c = NW'(n);
        return c;
    endfunction

    logic [NW-1:0] n0;
    logic [NW-1:0] n1;
    logic          is2d;

    assign n0   = clamp_pts(pf_reg);
    assign n1   = clamp_pts(ps_reg);
    assign is2d = dims_reg[1];

    // sequencer state
    gvi_pkg::gvi_state_t              state_reg, state_next;
    gvi_pkg::gvi_req_t                req_reg;
    logic [ACC_W-1:0]                 acc_reg, acc_next;
    logic                             dim_reg, dim_next;
    logic                             edge_reg, edge_next;
    logic signed [gvi_pkg::XW-1:0]    last_reg, last_next;
    logic [IW-1:0]                    i0_reg, i0_next, i1_reg, i1_next;
    logic [gvi_pkg::ALPHA_W-1:0]      a0_reg, a0_next, a1_reg, a1_next;
    logic [2:0]                       fcnt_reg, fcnt_next;
    logic [1:0]                       step_reg, step_next;
    logic [gvi_pkg::VAL_W-1:0]        d00_reg, d01_reg, d10_reg, d11_reg;
    logic [gvi_pkg::VAL_W-1:0]        v0_reg, v0_next, v1_reg, v1_next;
    logic [gvi_pkg::VAL_W-1:0]        res_reg, res_next;
    logic                             stat_reg, stat_next;
    logic                             rsp_valid_reg;
    gvi_pkg::gvi_rsp_t                rsp_reg;
    logic                             rsp_load;
    logic                             accept;

    assign req_stall = (state_reg != gvi_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // per-dimension operand select
    logic signed [gvi_pkg::VAL_W-1:0] x_sel;
    logic signed [gvi_pkg::VAL_W-1:0] org_sel;
    logic [gvi_pkg::SP_W-1:0]         sp_sel;
    logic [NW-1:0]                    n_sel;

    assign x_sel   = dim_reg ? req_reg.coord_second : req_reg.coord_first;
    assign org_sel = dim_reg ? os_reg : of_reg;
    assign sp_sel  = dim_reg ? ss_reg : sf_reg;
    assign n_sel   = dim_reg ? n1 : n0;

    // position of the last grid point and clamping of the coordinate
    logic [NW+gvi_pkg::SP_W-1:0]      span_prod;
    logic signed [gvi_pkg::XW-1:0]    x_ext, org_ext, xc, r;
    logic                             lo, hi;

    assign span_prod = (NW + gvi_pkg::SP_W)'(n_sel - 1'b1) * (NW + gvi_pkg::SP_W)'(sp_sel);
    assign x_ext     = gvi_pkg::XW'(x_sel);
    assign org_ext   = gvi_pkg::XW'(org_sel);
    assign lo        = (x_ext <= org_ext);
    assign hi        = (x_ext >= last_reg);

    always_comb
    begin
        xc = (x_ext > last_reg) ? last_reg : x_ext;
        xc = (xc < org_ext) ? org_ext : xc;
        r  = xc - org_ext;
    end

    // shared divider
    gvi_pkg::gvi_div_req_t            div_ctl;
    gvi_pkg::gvi_div_stat_t           div_stat;
    logic [gvi_pkg::DIV_W-1:0]        div_dividend;
    logic [gvi_pkg::ALPHA_W-1:0]      div_q;
    logic [gvi_pkg::DIV_W-1:0]        div_rem;
    logic [gvi_pkg::VAL_W-1:0]        off;

    assign off = gvi_pkg::VAL_W'(div_rem) + (is2d ? 32'd1 : 32'd0);

    gvi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (sp_sel),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // corner addresses; the base in acc_reg is already below the depth
    logic [IW+NW-1:0] row;
    logic [AW-1:0]    c00, c01, c10, c11, raddr;
    logic [gvi_pkg::VAL_W-1:0] rdata;
    logic             ram_we;

    assign row = (IW + NW)'(i1_reg) * (IW + NW)'(n0);
    assign c00 = acc_reg[AW-1:0] + AW'(row) + AW'(i0_reg);
    assign c10 = edge_reg ? c00 : c00 + 1'b1;
    assign c01 = is2d ? c00 + AW'(n0) : c00;
    assign c11 = is2d ? c10 + AW'(n0) : c10;

    always_comb
    begin
        case (fcnt_reg)
            3'd0:    raddr = c00;
            3'd1:    raddr = c01;
            3'd2:    raddr = c10;
            3'd3:    raddr = c11;
            default: raddr = c00;
        endcase
    end

    gvi_ram #(
        .WIDTH (gvi_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (acc_reg[AW-1:0]),
        .wdata (req_reg.entry_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // blend unit: a + round_half_up((b - a) * alpha / 2**16)
    logic signed [gvi_pkg::VAL_W-1:0]  la, lb;
    logic [gvi_pkg::ALPHA_W-1:0]       lal;
    logic signed [gvi_pkg::VAL_W:0]    ld;
    logic signed [50:0]                lp, lt, lq;
    logic [gvi_pkg::VAL_W-1:0]         ly;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                la  = d00_reg;
                lb  = d01_reg;
                lal = a1_reg;
            end
            2'd1:
            begin
                la  = d10_reg;
                lb  = d11_reg;
                lal = a1_reg;
            end
            default:
            begin
                la  = v0_reg;
                lb  = v1_reg;
                lal = a0_reg;
            end
        endcase
    end

    assign ld = (gvi_pkg::VAL_W + 1)'(lb) - (gvi_pkg::VAL_W + 1)'(la);
    assign lp = 51'(ld) * 51'($signed({1'b0, lal}));
    assign lt = lp + 51'sd32768;
    assign lq = lt >>> gvi_pkg::FRAC_W;
    // the blend stays between its two corners, so 32 bits always hold it
    assign ly = la + lq[gvi_pkg::VAL_W-1:0];

    // sequencer
    logic                         ld_i, ld_a, fin;
    logic [IW-1:0]                i_new;
    logic [gvi_pkg::ALPHA_W-1:0]  a_new;

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        dim_next     = dim_reg;
        edge_next    = edge_reg;
        last_next    = last_reg;
        i0_next      = i0_reg;
        i1_next      = i1_reg;
        a0_next      = a0_reg;
        a1_next      = a1_reg;
        fcnt_next    = fcnt_reg;
        step_next    = step_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        rsp_load     = 1'b0;
        ram_we       = 1'b0;
        div_ctl      = '0;
        div_dividend = gvi_pkg::DIV_W'(r);
        ld_i         = 1'b0;
        ld_a         = 1'b0;
        fin          = 1'b0;
        i_new        = '0;
        a_new        = '0;

        unique case (state_reg)
            gvi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dim_next  = 1'b0;
                    edge_next = 1'b0;
                    i1_next   = '0;
                    a1_next   = '0;
                    if (req.command == gvi_pkg::CMD_WRITE)
                    begin
                        acc_next   = ACC_W'(req.entry_address);
                        state_next = gvi_pkg::ST_WRAP;
                    end
                    else if (req.layer > ll_reg)
                    begin
                        res_next   = '0;
                        stat_next  = gvi_pkg::STATUS_RANGE;
                        state_next = gvi_pkg::ST_DONE;
                    end
                    else
                    begin
                        acc_next   = ACC_W'(req.layer) * ACC_W'(STRIDE);
                        state_next = gvi_pkg::ST_WRAP;
                    end
                end
            end
            gvi_pkg::ST_WRAP:
            begin
                // reduce the address modulo the store depth
                if (acc_reg >= ACC_W'(DEPTH))
                    acc_next = acc_reg - ACC_W'(DEPTH);
                else if (req_reg.command == gvi_pkg::CMD_WRITE)
                    state_next = gvi_pkg::ST_WRITE;
                else
                    state_next = gvi_pkg::ST_SPAN;
            end
            gvi_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = gvi_pkg::ST_IDLE;
            end
            gvi_pkg::ST_SPAN:
            begin
                last_next  = org_ext + gvi_pkg::XW'(span_prod);
                state_next = gvi_pkg::ST_CLAMP;
            end
            gvi_pkg::ST_CLAMP:
            begin
                if (!is2d && lo)
                begin
                    edge_next = 1'b1;
                    i_new     = '0;
                    ld_i      = 1'b1;
                    ld_a      = 1'b1;
                    fin       = 1'b1;
                end
                else if (!is2d && hi)
                begin
                    edge_next = 1'b1;
                    i_new     = IW'(n_sel - 1'b1);
                    ld_i      = 1'b1;
                    ld_a      = 1'b1;
                    fin       = 1'b1;
                end
                else if (is2d && r == '0)
                begin
                    ld_i = 1'b1;
                    ld_a = 1'b1;
                    fin  = 1'b1;
                end
                else
                begin
                    // 2-D finds the cell from r - 1 so an interior point
                    // lands at the top of the lower cell
                    div_dividend = gvi_pkg::DIV_W'(is2d ? r - 1 : r);
                    div_ctl.start = 1'b1;
                    div_ctl.top   = gvi_pkg::DIV_TOP_W'(IW - 1);
                    state_next    = gvi_pkg::ST_IDIV;
                end
            end
            gvi_pkg::ST_IDIV:
            begin
                if (div_stat.done)
                begin
                    i_new = div_q[IW-1:0];
                    ld_i  = 1'b1;
                    if (off == '0)
                    begin
                        ld_a = 1'b1;
                        fin  = 1'b1;
                    end
                    else
                    begin
                        div_dividend  = gvi_pkg::DIV_W'(off) << gvi_pkg::FRAC_W;
                        div_ctl.start = 1'b1;
                        div_ctl.top   = gvi_pkg::DIV_TOP_W'(gvi_pkg::ALPHA_W - 1);
                        state_next    = gvi_pkg::ST_ADIV;
                    end
                end
            end
            gvi_pkg::ST_ADIV:
            begin
                if (div_stat.done)
                begin
                    a_new = div_q;
                    ld_a  = 1'b1;
                    fin   = 1'b1;
                end
            end
            gvi_pkg::ST_FETCH:
            begin
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == 3'd4)
                begin
                    step_next  = 2'd0;
                    state_next = gvi_pkg::ST_BLEND;
                end
            end
            gvi_pkg::ST_BLEND:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    2'd0:    v0_next = ly;
                    2'd1:    v1_next = ly;
                    default:
                    begin
                        res_next   = ly;
                        stat_next  = gvi_pkg::STATUS_OK;
                        state_next = gvi_pkg::ST_DONE;
                    end
                endcase
            end
            gvi_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = gvi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gvi_pkg::ST_IDLE;
            end
        endcase

        if (ld_i)
        begin
            if (dim_reg)
                i1_next = i_new;
            else
                i0_next = i_new;
        end
        if (ld_a)
        begin
            if (dim_reg)
                a1_next = a_new;
            else
                a0_next = a_new;
        end
        // move to the second dimension or on to the table reads
        if (fin)
        begin
            if (is2d && !dim_reg)
            begin
                dim_next   = 1'b1;
                state_next = gvi_pkg::ST_SPAN;
            end
            else
            begin
                fcnt_next  = '0;
                state_next = gvi_pkg::ST_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gvi_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        acc_reg  <= acc_next;
        dim_reg  <= dim_next;
        edge_reg <= edge_next;
        last_reg <= last_next;
        i0_reg   <= i0_next;
        i1_reg   <= i1_next;
        a0_reg   <= a0_next;
        a1_reg   <= a1_next;
        fcnt_reg <= fcnt_next;
        step_reg <= step_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        // read data comes from the store's output register, in the cycle after its address
        if (state_reg == gvi_pkg::ST_FETCH)
        begin
            case (fcnt_reg)
                3'd1:    d00_reg <= rdata;
                3'd2:    d01_reg <= rdata;
                3'd3:    d10_reg <= rdata;
                3'd4:    d11_reg <= rdata;
                default: ;
            endcase
        end
        if (rsp_load)
        begin
            rsp_reg.value  <= res_reg;
            rsp_reg.status <= stat_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `GVI_ASSERT_IMPLIES(a_range_zero, clk, rst_n, rsp_valid_reg && rsp_reg.status == gvi_pkg::STATUS_RANGE, rsp_reg.value == '0)
    `GVI_ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == gvi_pkg::ST_DONE && (!rsp_valid_reg || !rsp_stall), rsp_valid_reg && state_reg == gvi_pkg::ST_IDLE)
    `GVI_ASSERT_NEXT(a_alpha_max, clk, rst_n, state_reg == gvi_pkg::ST_ADIV && div_stat.done, a0_reg <= gvi_pkg::ALPHA_ONE && a1_reg <= gvi_pkg::ALPHA_ONE)
    `GVI_ASSERT_IMPLIES(a_div_idle, clk, rst_n, state_reg == gvi_pkg::ST_IDLE, !div_stat.busy)

endmodule
